[rtl/serial_bank_switch_mapper_unit_macros.svh]
// Assertion macros for the serial bank switch mapper.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSM_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBSM_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("%m: assertion failed");

`endif

[rtl/sbsm_pkg.sv]
// Shared types and constants of the serial bank switch mapper.
// Depends on nothing; used by the interfaces and every module.
package sbsm_pkg;

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int OFF_W      = 19;
    localparam int MIRR_W     = 3;
    localparam int REG_W      = 5;
    localparam int PRG_CNT_W  = 6;
    localparam int CHR_CNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Width of the shared remainder unit; holds any bank count or page index.
    localparam int MOD_W = 7;
    localparam int CNT_W = $clog2(MOD_W);

    localparam int DEF_MAX_PRG_BANKS = 32;
    localparam int DEF_MAX_CHR_BANKS = 64;

    localparam logic [REG_W-1:0]     SHIFT_RESET     = 5'h10;
    localparam logic [REG_W-1:0]     CTRL_RESET      = 5'h0C;
    localparam logic [REG_W-1:0]     CTRL_PRG_FORCE  = 5'h0C;
    localparam logic [PRG_CNT_W-1:0] PRG_BANKS_RESET = 6'd16;
    localparam logic [CHR_CNT_W-1:0] CHR_BANKS_RESET = 7'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CPU_WR = 2'd0,
        FUNC_CPU_RD = 2'd1,
        FUNC_GFX_RD = 2'd2,
        FUNC_GFX_WR = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_BANKS   = 2'd0,
        CFG_CHR_BANKS   = 2'd1,
        CFG_CHR_RAM     = 2'd2,
        CFG_FOUR_SCREEN = 2'd3
    } t_cfg_idx;

    // Target of a serial commit, taken from CPU address bits 14:13.
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } t_reg_sel;

    typedef enum logic [MIRR_W-1:0] {
        MIRR_ONE_LOW  = 3'd0,
        MIRR_ONE_HIGH = 3'd1,
        MIRR_VERT     = 3'd2,
        MIRR_HORIZ    = 3'd3,
        MIRR_FOUR     = 3'd4
    } t_mirroring;

    typedef enum logic [1:0] {
        PRG_MODE_32K_A    = 2'd0,
        PRG_MODE_32K_B    = 2'd1,
        PRG_MODE_FIX_LOW  = 2'd2,
        PRG_MODE_FIX_HIGH = 2'd3
    } t_prg_mode;

    typedef struct packed {
        logic [REG_W-1:0] control;
        logic [REG_W-1:0] chr_low;
        logic [REG_W-1:0] chr_high;
        logic [REG_W-1:0] prg;
    } t_bank_regs;

endpackage

[rtl/sbsm_in_if.sv]
// Input channel of the mapper: one bus access per beat.
// Depends on sbsm_pkg.
interface sbsm_in_if import sbsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] bus_addr;
    logic [BYTE_W-1:0] write_byte;

    modport source(output valid, output func, output bus_addr, output write_byte,
                   input ready);
    modport sink(input valid, input func, input bus_addr, input write_byte,
                 output ready);
endinterface

[rtl/sbsm_out_if.sv]
// Output channel of the mapper: one translated access per beat.
// Depends on sbsm_pkg.
interface sbsm_out_if import sbsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [OFF_W-1:0]  mem_offset;
    logic              mem_write;
    logic [MIRR_W-1:0] mirroring;

    modport source(output valid, output hit, output mem_offset, output mem_write,
                   output mirroring, input ready);
    modport sink(input valid, input hit, input mem_offset, input mem_write,
                 input mirroring, output ready);
endinterface

[rtl/sbsm_serial_regs.sv]
// Serial loading shift register and the four bank registers it commits to.
// Depends on sbsm_pkg.
module sbsm_serial_regs import sbsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [BYTE_W-1:0] i_data,
    output t_bank_regs        o_regs
);

    logic [REG_W-1:0] r_shift;
    t_bank_regs       r_regs;
    logic [REG_W-1:0] n_shift;

    // The new bit enters at the top; the marker bit reaching bit 0 means this write brings the fifth bit.
    assign n_shift = {i_data[0], r_shift[REG_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift          <= SHIFT_RESET;
            r_regs.control   <= CTRL_RESET;
            r_regs.chr_low   <= '0;
            r_regs.chr_high  <= '0;
            r_regs.prg       <= '0;
        end else if (i_wr_en && i_addr[ADDR_W-1]) begin
            if (i_data[BYTE_W-1]) begin
                r_shift        <= SHIFT_RESET;
                r_regs.control <= r_regs.control | CTRL_PRG_FORCE;
            end else if (r_shift[0]) begin
                r_shift <= SHIFT_RESET;
                case (t_reg_sel'(i_addr[14:13]))
                    SEL_CONTROL:  r_regs.control  <= n_shift;
                    SEL_CHR_LOW:  r_regs.chr_low  <= n_shift;
                    SEL_CHR_HIGH: r_regs.chr_high <= n_shift;
                    SEL_PRG:      r_regs.prg      <= n_shift;
                    default:      r_regs.prg      <= n_shift;
                endcase
            end else begin
                r_shift <= n_shift;
            end
        end
    end

    assign o_regs = r_regs;

endmodule

[rtl/sbsm_mod_unit.sv]
// Shared restoring remainder unit, one quotient bit per cycle.
// Depends on sbsm_pkg.
module sbsm_mod_unit import sbsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MOD_W-1:0] i_dividend,
    input  logic [MOD_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [MOD_W-1:0] o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MOD_W-1:0] r_rem;
    logic [MOD_W-1:0] r_dvd;
    logic [MOD_W-1:0] r_div;

    logic [MOD_W:0]   w_shift;
    logic [MOD_W:0]   w_diff;
    logic             w_ge;
    logic [MOD_W-1:0] n_rem;

    assign w_shift = {r_rem, r_dvd[MOD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};
    // The partial remainder stays below the divisor, so it fits in MOD_W bits.
    assign n_rem   = w_ge ? w_diff[MOD_W-1:0] : w_shift[MOD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MOD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[MOD_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/serial_bank_switch_mapper_unit.sv]
// Serial-loaded bank switching cartridge mapper: top level with sequencer.
// Depends on sbsm_pkg, sbsm_in_if, sbsm_out_if, sbsm_serial_regs, sbsm_mod_unit
// and serial_bank_switch_mapper_unit_macros.svh.
//
// Each input beat is one bus access and yields exactly one output beat. CPU
// writes at or above 0x8000 feed the five-bit serial loader; their results
// carry zeros and the mirroring mode after the write. CPU reads and graphics
// accesses are translated to a byte offset in PRG ROM, CHR ROM or CHR RAM.
// CPU writes, misses and CHR RAM accesses skip the remainder unit and go from
// the idle state straight to the hold state that loads the output register.
// ROM translations run two remainder passes through one shared restoring
// unit (one bank index modulo a bank count, then a 4K or 16K page modulo the
// bank count) in the states ST_MOD_A and ST_MOD_B before the hold state.
// The input
// takes a new beat only while the sequencer is idle; a finished result waits
// in the output register, so the next access can be taken and worked on while
// the previous result is still unclaimed.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only change while no access is in flight. Bank counts
// above MAX_PRG_BANKS or MAX_CHR_BANKS saturate to those limits.
`include "serial_bank_switch_mapper_unit_macros.svh"

module serial_bank_switch_mapper_unit import sbsm_pkg::*; #(
    parameter int MAX_PRG_BANKS = DEF_MAX_PRG_BANKS,
    parameter int MAX_CHR_BANKS = DEF_MAX_CHR_BANKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sbsm_in_if.sink               i_in,
    sbsm_out_if.source            o_out
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MOD_A = 4'b0010,
        ST_MOD_B = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_state;

    // Configuration registers.
    logic [PRG_CNT_W-1:0] r_prg_banks;
    logic [CHR_CNT_W-1:0] r_chr_banks;
    logic                 r_chr_ram;
    logic                 r_four;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_banks <= PRG_BANKS_RESET;
            r_chr_banks <= CHR_BANKS_RESET;
            r_chr_ram   <= 1'b1;
            r_four      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PRG_BANKS:   r_prg_banks <= i_cfg_data[PRG_CNT_W-1:0];
                CFG_CHR_BANKS:   r_chr_banks <= i_cfg_data[CHR_CNT_W-1:0];
                CFG_CHR_RAM:     r_chr_ram   <= i_cfg_data[0];
                CFG_FOUR_SCREEN: r_four      <= i_cfg_data[0];
                default:         r_four      <= i_cfg_data[0];
            endcase
        end
    end

    // Effective bank counts after saturation.
    logic [MOD_W-1:0] w_prg_b;
    logic [MOD_W-1:0] w_chr_b;
    logic [MOD_W-1:0] w_prg_b32;
    logic [MOD_W-1:0] w_chr_b8;

    assign w_prg_b   = ({1'b0, r_prg_banks} > MOD_W'(MAX_PRG_BANKS)) ?
                       MOD_W'(MAX_PRG_BANKS) : {1'b0, r_prg_banks};
    assign w_chr_b   = (r_chr_banks > MOD_W'(MAX_CHR_BANKS)) ?
                       MOD_W'(MAX_CHR_BANKS) : r_chr_banks;
    assign w_prg_b32 = (w_prg_b[MOD_W-1:1] == '0) ? MOD_W'(1) : {1'b0, w_prg_b[MOD_W-1:1]};
    assign w_chr_b8  = (w_chr_b[MOD_W-1:1] == '0) ? MOD_W'(1) : {1'b0, w_chr_b[MOD_W-1:1]};

    t_state     r_state;
    t_bank_regs w_regs;
    logic       w_in_accept;
    logic       w_cpu_wr;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_cpu_wr    = w_in_accept && (t_func'(i_in.func) == FUNC_CPU_WR);

    sbsm_serial_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_cpu_wr),
        .i_addr  (i_in.bus_addr),
        .i_data  (i_in.write_byte),
        .o_regs  (w_regs)
    );

    // Plan for the accepted access: either a direct result or the operands of
    // the first remainder pass and how to form the page for the second one.
    logic             w_need_mod;
    logic             w_p_hit;
    logic [OFF_W-1:0] w_p_off;
    logic             w_p_wr;
    logic [MOD_W-1:0] w_p_x1;
    logic [MOD_W-1:0] w_p_d1;
    logic [MOD_W-1:0] w_p_d2;
    logic             w_p_pair;
    logic             w_p_bit;
    logic             w_p_is_prg;
    logic [12:0]      w_gfx_a;
    logic [REG_W-1:0] w_chr_bank;

    assign w_gfx_a    = i_in.bus_addr[12:0];
    assign w_chr_bank = w_gfx_a[12] ? w_regs.chr_high : w_regs.chr_low;

    always_comb begin
        w_need_mod = 1'b0;
        w_p_hit    = 1'b0;
        w_p_off    = '0;
        w_p_wr     = 1'b0;
        w_p_x1     = '0;
        w_p_d1     = MOD_W'(1);
        w_p_d2     = MOD_W'(1);
        w_p_pair   = 1'b0;
        w_p_bit    = 1'b0;
        w_p_is_prg = 1'b0;
        case (t_func'(i_in.func))
            FUNC_CPU_WR: begin
                w_need_mod = 1'b0;
            end
            FUNC_CPU_RD: begin
                if (i_in.bus_addr[ADDR_W-1] && (w_prg_b != '0)) begin
                    w_need_mod = 1'b1;
                    w_p_hit    = 1'b1;
                    w_p_is_prg = 1'b1;
                    w_p_d2     = w_prg_b;
                    case (t_prg_mode'(w_regs.control[3:2]))
                        PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                            w_p_x1   = MOD_W'(w_regs.prg[3:1]);
                            w_p_d1   = w_prg_b32;
                            w_p_pair = 1'b1;
                            w_p_bit  = i_in.bus_addr[14];
                        end
                        PRG_MODE_FIX_LOW: begin
                            w_p_x1 = i_in.bus_addr[14] ? MOD_W'(w_regs.prg) : '0;
                            w_p_d1 = w_prg_b;
                        end
                        PRG_MODE_FIX_HIGH: begin
                            w_p_x1 = i_in.bus_addr[14] ? (w_prg_b - MOD_W'(1)) :
                                     MOD_W'(w_regs.prg);
                            w_p_d1 = w_prg_b;
                        end
                        default: begin
                            w_p_x1 = '0;
                        end
                    endcase
                end
            end
            FUNC_GFX_RD, FUNC_GFX_WR: begin
                if (w_chr_b == '0) begin
                    // CHR RAM: the offset wraps inside 8K, no division needed.
                    if (r_chr_ram) begin
                        w_p_hit = 1'b1;
                        w_p_wr  = (t_func'(i_in.func) == FUNC_GFX_WR);
                        w_p_off = w_regs.control[4] ?
                                  OFF_W'({w_chr_bank[0], w_gfx_a[11:0]}) :
                                  OFF_W'(w_gfx_a);
                    end
                end else if (t_func'(i_in.func) == FUNC_GFX_RD) begin
                    w_need_mod = 1'b1;
                    w_p_hit    = 1'b1;
                    w_p_d2     = w_chr_b;
                    if (w_regs.control[4]) begin
                        w_p_x1 = MOD_W'(w_chr_bank);
                        w_p_d1 = w_chr_b;
                    end else begin
                        w_p_x1   = MOD_W'(w_regs.chr_low[4:1]);
                        w_p_d1   = w_chr_b8;
                        w_p_pair = 1'b1;
                        w_p_bit  = w_gfx_a[12];
                    end
                end
            end
            default: begin
                w_need_mod = 1'b0;
            end
        endcase
    end

    // Shared remainder unit and its operand selection.
    logic             w_mod_start;
    logic [MOD_W-1:0] w_mod_dvd;
    logic [MOD_W-1:0] w_mod_div;
    logic             w_mod_busy;
    logic             w_mod_done;
    logic [MOD_W-1:0] w_mod_rem;
    logic [MOD_W-1:0] w_page;

    logic             r_pair;
    logic             r_bit;
    logic [MOD_W-1:0] r_d2;
    logic             r_is_prg;
    logic [13:0]      r_low;

    // In the paired modes the bank picks a double-size page and the address bit
    // picks its half.
    assign w_page      = r_pair ? {w_mod_rem[MOD_W-2:0], r_bit} : w_mod_rem;
    assign w_mod_start = (w_in_accept && w_need_mod) || ((r_state == ST_MOD_A) && w_mod_done);
    assign w_mod_dvd   = (r_state == ST_IDLE) ? w_p_x1 : w_page;
    assign w_mod_div   = (r_state == ST_IDLE) ? w_p_d1 : r_d2;

    sbsm_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_mod_div),
        .o_busy     (w_mod_busy),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Result staging and output register.
    logic              r_hit;
    logic [OFF_W-1:0]  r_off;
    logic              r_wr;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [OFF_W-1:0]  r_out_off;
    logic              r_out_wr;
    logic [MIRR_W-1:0] r_out_mirr;
    logic              w_out_load;
    logic [MIRR_W-1:0] w_mirr;

    assign w_out_load = (r_state == ST_HOLD) && (!r_out_valid || o_out.ready);
    assign w_mirr     = r_four ? MIRR_FOUR : {1'b0, w_regs.control[1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= w_need_mod ? ST_MOD_A : ST_HOLD;
                    end
                end
                ST_MOD_A: begin
                    if (w_mod_done) begin
                        r_state <= ST_MOD_B;
                    end
                end
                ST_MOD_B: begin
                    if (w_mod_done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_hit    <= w_p_hit;
            r_off    <= w_p_off;
            r_wr     <= w_p_wr;
            r_pair   <= w_p_pair;
            r_bit    <= w_p_bit;
            r_d2     <= w_p_d2;
            r_is_prg <= w_p_is_prg;
            r_low    <= i_in.bus_addr[13:0];
        end else if ((r_state == ST_MOD_B) && w_mod_done) begin
            r_off <= r_is_prg ? {w_mod_rem[4:0], r_low} :
                                OFF_W'({w_mod_rem[5:0], r_low[11:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hit  <= r_hit;
            r_out_off  <= r_off;
            r_out_wr   <= r_wr;
            r_out_mirr <= w_mirr;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_out_hit;
    assign o_out.mem_offset = r_out_off;
    assign o_out.mem_write  = r_out_wr;
    assign o_out.mirroring  = r_out_mirr;

    // The shared unit only runs while a translation is in progress.
    `SBSM_ASSERT_IMP(a_mod_idle, (r_state == ST_IDLE) || (r_state == ST_HOLD), !w_mod_busy)
    // A CPU write never uses the remainder unit and goes straight to the result.
    `SBSM_ASSERT_NXT(a_wr_direct, w_cpu_wr, r_state == ST_HOLD)
    // Only a hit may store to CHR RAM.
    `SBSM_ASSERT_IMP(a_wr_hit, r_out_valid && r_out_wr, r_out_hit)

endmodule

[dv/serial_bank_switch_mapper_unit_test.sv]
// Self-checking testbench for the serial bank switch mapper.
// Depends on sbsm_pkg, sbsm_in_if, sbsm_out_if and serial_bank_switch_mapper_unit.
`timescale 1ns / 1ps

module serial_bank_switch_mapper_unit_test;
    import sbsm_pkg::*;

    // Address map and page sizes of the cartridge bus.
    localparam logic [ADDR_W-1:0] CPU_ROM_BASE  = 16'h8000;
    localparam logic [ADDR_W-1:0] CPU_HIGH_BASE = 16'hC000;
    localparam logic [12:0]       CHR_HALF      = 13'h1000;
    localparam int unsigned       PRG_PAGE      = 32'h4000;
    localparam int unsigned       PRG_PAGE32    = 32'h8000;
    localparam int unsigned       CHR_PAGE      = 32'h1000;
    localparam int unsigned       CHR_PAGE8     = 32'h2000;
    localparam int unsigned       CHR_RAM_MASK  = 32'h1FFF;

    // Extra wait after the last result; it covers a ROM translation with margin.
    localparam int DRAIN_CYCLES   = 40;
    // Cycles without any beat on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the deliberate output stall that backs the block up.
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 108;

    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] mem_offset;
        logic             mem_write;
        t_mirroring       mirroring;
    } t_mapped_access;

    // Tracks the mapper state, turns every accepted bus access into the
    // translated access the block must return, and compares returned beats
    // in order against those predictions.
    class mapper_scoreboard;
        logic [PRG_CNT_W-1:0] prg_banks;
        logic [CHR_CNT_W-1:0] chr_banks;
        logic                 chr_ram;
        logic                 four_scr;
        logic [REG_W-1:0]     shift_q;
        logic [REG_W-1:0]     ctrl_q;
        logic [REG_W-1:0]     chr_lo_q;
        logic [REG_W-1:0]     chr_hi_q;
        logic [REG_W-1:0]     prg_q;
        t_mapped_access       expected_q[$];
        int                   errors;

        function new();
            prg_banks = PRG_BANKS_RESET;
            chr_banks = CHR_BANKS_RESET;
            chr_ram   = 1'b1;
            four_scr  = 1'b0;
            shift_q   = SHIFT_RESET;
            ctrl_q    = CTRL_RESET;
            chr_lo_q  = '0;
            chr_hi_q  = '0;
            prg_q     = '0;
            errors    = 0;
        endfunction

        function void set_config(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_PRG_BANKS:   prg_banks = v[PRG_CNT_W-1:0];
                CFG_CHR_BANKS:   chr_banks = v[CHR_CNT_W-1:0];
                CFG_CHR_RAM:     chr_ram   = v[0];
                CFG_FOUR_SCREEN: four_scr  = v[0];
                default:         four_scr  = v[0];
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_access(t_func f, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
            t_mapped_access   r;
            int unsigned      banks, span, page, o;
            logic [12:0]      ga;
            logic             commit;
            r = '0;
            o = 0;
            case (f)
                FUNC_CPU_WR: begin
                    if (a >= CPU_ROM_BASE) begin
                        if (d[7]) begin
                            shift_q = SHIFT_RESET;
                            ctrl_q  = ctrl_q | CTRL_PRG_FORCE;
                        end else begin
                            // The marker bit reaching bit 0 means this is the fifth bit.
                            commit  = shift_q[0];
                            shift_q = {d[0], shift_q[REG_W-1:1]};
                            if (commit) begin
                                case (t_reg_sel'(a[14:13]))
                                    SEL_CONTROL:  ctrl_q   = shift_q;
                                    SEL_CHR_LOW:  chr_lo_q = shift_q;
                                    SEL_CHR_HIGH: chr_hi_q = shift_q;
                                    SEL_PRG:      prg_q    = shift_q;
                                    default:      prg_q    = shift_q;
                                endcase
                                shift_q = SHIFT_RESET;
                            end
                        end
                    end
                end
                FUNC_CPU_RD: begin
                    banks = (prg_banks > DEF_MAX_PRG_BANKS) ? DEF_MAX_PRG_BANKS : prg_banks;
                    if (a >= CPU_ROM_BASE && banks != 0) begin
                        span = (banks / 2 == 0) ? 1 : banks / 2;
                        case (t_prg_mode'(ctrl_q[3:2]))
                            PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                                o = (prg_q[3:1] % span) * PRG_PAGE32 + (a - CPU_ROM_BASE);
                            end
                            PRG_MODE_FIX_LOW: begin
                                page = (a < CPU_HIGH_BASE) ? 0 : prg_q % banks;
                                o    = page * PRG_PAGE + a[13:0];
                            end
                            default: begin
                                page = (a < CPU_HIGH_BASE) ? prg_q % banks : banks - 1;
                                o    = page * PRG_PAGE + a[13:0];
                            end
                        endcase
                        r.hit        = 1'b1;
                        r.mem_offset = OFF_W'(o % (banks * PRG_PAGE));
                    end
                end
                default: begin
                    // Graphics accesses see only the low 13 address bits.
                    banks = (chr_banks > DEF_MAX_CHR_BANKS) ? DEF_MAX_CHR_BANKS : chr_banks;
                    ga    = a[12:0];
                    if (banks == 0) begin
                        if (chr_ram) begin
                            if (ctrl_q[4])
                                o = ((ga < CHR_HALF) ? chr_lo_q : chr_hi_q) * CHR_PAGE + ga[11:0];
                            else
                                o = chr_lo_q[4:1] * CHR_PAGE8 + ga;
                            r.hit        = 1'b1;
                            r.mem_offset = OFF_W'(o & CHR_RAM_MASK);
                            r.mem_write  = (f == FUNC_GFX_WR);
                        end
                    end else if (f == FUNC_GFX_RD) begin
                        if (ctrl_q[4]) begin
                            o = (((ga < CHR_HALF) ? chr_lo_q : chr_hi_q) % banks) * CHR_PAGE
                                + ga[11:0];
                        end else begin
                            span = (banks / 2 == 0) ? 1 : banks / 2;
                            o    = (chr_lo_q[4:1] % span) * CHR_PAGE8 + ga;
                        end
                        r.hit        = 1'b1;
                        r.mem_offset = OFF_W'(o % (banks * CHR_PAGE));
                    end
                end
            endcase
            r.mirroring = four_scr ? MIRR_FOUR : t_mirroring'({1'b0, ctrl_q[1:0]});
            expected_q.push_back(r);
        endfunction

        function void check_result(logic hit, logic [OFF_W-1:0] off, logic wr,
                                   logic [MIRR_W-1:0] mirr);
            t_mapped_access e;
            if (expected_q.size() == 0) begin
                $error("output beat with no access outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, hit);
                errors++;
            end
            if (off !== e.mem_offset) begin
                $error("mem_offset: expected 0x%05h, got 0x%05h", e.mem_offset, off);
                errors++;
            end
            if (wr !== e.mem_write) begin
                $error("mem_write: expected %0d, got %0d", e.mem_write, wr);
                errors++;
            end
            if (mirr !== e.mirroring) begin
                $error("mirroring: expected %0d, got %0d", e.mirroring, mirr);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sbsm_in_if  in_if();
    sbsm_out_if out_if();

    mapper_scoreboard sb = new();

    // Idle percentages of the two sides; changed per phase by the main sequence.
    int tx_idle_pct;
    int rx_idle_pct;
    // Cycles the receiver still has to hold off; counted down in its own process.
    int rx_hold;
    int items_sent;

    serial_bank_switch_mapper_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides its ready at each falling edge. A pending hold-off
    // wins over the random idling so that the block backs up into its input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                rx_hold--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Every output beat is checked at the rising edge that transfers it.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.hit, out_if.mem_offset, out_if.mem_write, out_if.mirroring);
    end

    // The watchdog restarts on every beat of either channel. If the block
    // hangs, the run ends with the failure message once WATCHDOG_LIMIT is hit.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one bus access, with random idle cycles ahead of it, and notes
    // it in the scoreboard at the rising edge that accepts it. Called and
    // returns at a falling edge.
    task automatic send_access(input t_func f, input logic [ADDR_W-1:0] a,
                               input logic [BYTE_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= f;
        in_if.bus_addr   <= a;
        in_if.write_byte <= d;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_access(f, a, d);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Shifts a five-bit value in LSB first. Only the last write's address
    // picks the target register; the other data bits are noise the block
    // must ignore.
    task automatic load_serial(input logic [REG_W-1:0] value, input logic [ADDR_W-1:0] target);
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < REG_W; i++) begin
            a = (i == REG_W - 1) ? target : ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
            send_access(FUNC_CPU_WR, a, {1'b0, 6'($urandom_range(63)), value[i]});
        end
    endtask

    // Lets every outstanding access come back, then a little more so the
    // sequencer is surely idle before configuration changes.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes all four registers on consecutive edges; the write enable stays
    // high throughout and drops once afterwards.
    task automatic apply_config(input int prg, input int chr, input int ram, input int fs);
        t_cfg_idx idx;
        int       vals[4];
        vals = '{prg, chr, ram, fs};
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            idx        = t_cfg_idx'(i);
            i_cfg_idx  <= idx;
            i_cfg_data <= CFG_DATA_W'(vals[i]);
            sb.set_config(idx, CFG_DATA_W'(vals[i]));
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random traffic. Most of it is well-formed serial loads, mixed at random
    // with reads that exercise the committed bank registers; the rest is
    // graphics traffic and unconstrained noise that also breaks sequences.
    task automatic run_random(input int n_items);
        int                stop_at;
        int                pick;
        logic [ADDR_W-1:0] a;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(3) == 0)
                    send_access(FUNC_CPU_WR, ADDR_W'($urandom_range(16'h8000, 16'hFFFF)),
                                8'h80 | 8'($urandom_range(127)));
                load_serial(REG_W'($urandom_range(31)),
                            ADDR_W'($urandom_range(16'h8000, 16'hFFFF)));
            end else if (pick < 65) begin
                a = ($urandom_range(7) == 0) ? ADDR_W'($urandom)
                                             : ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
                send_access(FUNC_CPU_RD, a, 8'($urandom));
            end else if (pick < 90) begin
                send_access($urandom_range(1) ? FUNC_GFX_WR : FUNC_GFX_RD,
                            ADDR_W'($urandom), 8'($urandom));
            end else begin
                send_access(t_func'($urandom_range(3)), ADDR_W'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        int prg, chr, ram, fs;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_PRG_BANKS;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_CPU_RD;
        in_if.bus_addr   = '0;
        in_if.write_byte = '0;
        out_if.ready     = 1'b0;
        tx_idle_pct      = 7;
        rx_idle_pct      = 80;
        rx_hold          = 0;
        items_sent       = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset configuration: 256K PRG ROM and CHR RAM,
        // with the last PRG bank fixed at 0xC000.
        send_access(FUNC_CPU_RD, 16'h8000, 8'h00);
        send_access(FUNC_CPU_RD, 16'hFFFF, 8'hFF);
        send_access(FUNC_CPU_RD, 16'h7FFF, 8'h00);      // below ROM space: miss
        send_access(FUNC_CPU_RD, 16'h0000, 8'h00);
        send_access(FUNC_GFX_RD, 16'h0000, 8'h00);
        send_access(FUNC_GFX_WR, 16'h1FFF, 8'hFF);      // CHR RAM accepts the write
        send_access(FUNC_GFX_RD, 16'hFFFF, 8'h00);      // upper address bits dropped
        send_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF);      // below 0x8000: no effect
        send_access(FUNC_CPU_WR, 16'h8000, 8'h80);      // serial reset
        load_serial(5'h1F, 16'h9FFF);                   // control: 4K CHR, mode 3, horizontal
        send_access(FUNC_CPU_RD, 16'hC000, 8'h00);
        send_access(FUNC_GFX_RD, 16'h1000, 8'h00);
        load_serial(5'h1F, 16'hE000);                   // PRG bank register at its top
        send_access(FUNC_CPU_RD, 16'hBFFF, 8'h00);
        send_access(FUNC_CPU_WR, 16'hFFFF, 8'hFF);      // reset with every data bit set

        for (int p = 0; p < PHASES; p++) begin
            // Idling: sender rarely and receiver mostly first, then the
            // reverse, then full throughput on both sides.
            tx_idle_pct = (p < 3) ? 7 : (p < 6) ? 80 : 0;
            rx_idle_pct = (p < 3) ? 80 : (p < 6) ? 7 : 0;
            if (p > 0) begin
                settle();
                case (p)
                    1: apply_config(32, 64, 0, 1);
                    2: apply_config(0, 0, 0, 0);
                    3: apply_config(63, 127, 1, 0);
                    4: apply_config(1, 1, 1, 1);
                    5: apply_config(2, 0, 1, 0);
                    default: begin
                        prg = $urandom_range(63);
                        chr = $urandom_range(1) ? 0 : $urandom_range(1, 127);
                        ram = $urandom_range(1);
                        fs  = $urandom_range(1);
                        apply_config(prg, chr, ram, fs);
                    end
                endcase
            end
            // The sender keeps pushing at full rate while the receiver
            // stalls, so the output register and the sequencer fill up.
            if (p == 6)
                rx_hold = HOLD_OFF_LEN;
            run_random(PHASE_ITEMS);
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/sbsm_pkg.sv
rtl/sbsm_in_if.sv
rtl/sbsm_out_if.sv
rtl/sbsm_serial_regs.sv
rtl/sbsm_mod_unit.sv
rtl/serial_bank_switch_mapper_unit.sv
dv/serial_bank_switch_mapper_unit_test.sv
